// ===== rtl/mfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame slot manager package
// Shared widths, operation codes and slot states.
// ----------------------------------------------------------------------------
`default_nettype none

package mfsm_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 4;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned SLOT_W         = 2;
  localparam int unsigned MASK_W         = 4;
  localparam int unsigned SUB_W          = 64;
  localparam int unsigned REUSE_GAP      = 2;

  typedef enum logic [2:0] {
    OP_ACQUIRE = 3'd0,
    OP_COMMIT  = 3'd1,
    OP_POLL    = 3'd2,
    OP_OPENED  = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_FREE      = 3'd0,
    ST_WRITING   = 3'd1,
    ST_PENDING   = 3'd2,
    ST_PUBLISHED = 3'd3,
    ST_RETIRED   = 3'd4
  } slot_state_e;

  typedef logic [SUB_W-1:0] sub_t;

endpackage

`default_nettype wire

// ===== rtl/mfsm_newest_sel.sv =====
// ----------------------------------------------------------------------------
// Newest completed slot selector
// Picks the eligible slot with the largest submission number, lowest on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module mfsm_newest_sel #(
  parameter int unsigned SLOT_COUNT = mfsm_pkg::SLOT_COUNT_DEF,
  localparam int unsigned IdxW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic [SLOT_COUNT-1:0] eligible_i,
  input  wire mfsm_pkg::sub_t        sub_i [SLOT_COUNT],
  output logic                       found_o,
  output logic [IdxW-1:0]            newest_o
);

  logic [SLOT_COUNT-1:0] win;

  // All pairwise compares run in parallel; at most one eligible slot survives, exactly one when any is eligible.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      win[i] = eligible_i[i];
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (j < i) begin
          if (eligible_i[j] && !(sub_i[i] > sub_i[j])) win[i] = 1'b0;
        end else if (j > i) begin
          if (eligible_i[j] && (sub_i[i] < sub_i[j])) win[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    newest_o = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (win[i]) newest_o = newest_o | IdxW'(i);
    end
  end

  assign found_o = |eligible_i;

endmodule

`default_nettype wire

// ===== rtl/mailbox_frame_slot_manager.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame slot manager
// Tracks frame-buffer slots through free, writing, pending, published and
// retired, driven by acquire, commit, poll, handle-opened and clear words.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (op_i, slot_index_i, fence_done_mask_i, signal_failed_i)
//   is taken at a rising edge where start is high and busy is low. busy is
//   never raised, so one word can be taken in every cycle.
//   Each word is first captured in an input register. In the next cycle the
//   slot update logic evaluates it against the slot table and loads the
//   result register, so the result word appears with result_valid_o high
//   for one cycle once the result register is loaded. Throughput is one
//   word per cycle; the slot table update completes in the same edge that
//   loads the result, so back-to-back words see it.
//   The result strobe cannot be held off by the receiver; a missed result
//   word is lost.
//   Reset makes every slot free, clears all submission numbers and flags,
//   and leaves nothing published. A clear word does the same in-band.
// ----------------------------------------------------------------------------
`default_nettype none

module mailbox_frame_slot_manager #(
  parameter int unsigned SLOT_COUNT = mfsm_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mfsm_pkg::OP_W-1:0]   op_i,
  input  wire logic [mfsm_pkg::SLOT_W-1:0] slot_index_i,
  input  wire logic [mfsm_pkg::MASK_W-1:0] fence_done_mask_i,
  input  wire logic                        signal_failed_i,
  output logic                             result_valid_o,
  output logic                             write_valid_o,
  output logic [mfsm_pkg::SLOT_W-1:0]      write_slot_o,
  output logic                             commit_taken_o,
  output logic                             fresh_frame_o,
  output logic                             has_frame_o,
  output logic [mfsm_pkg::SLOT_W-1:0]      latest_slot_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Input register
  logic                          in_valid_q;
  logic [mfsm_pkg::OP_W-1:0]     op_q;
  logic [mfsm_pkg::SLOT_W-1:0]   slot_index_q;
  logic [mfsm_pkg::MASK_W-1:0]   mask_q;
  logic                          failed_q;

  // Slot table and bookkeeping
  mfsm_pkg::slot_state_e st_q     [SLOT_COUNT];
  mfsm_pkg::slot_state_e st_d     [SLOT_COUNT];
  mfsm_pkg::sub_t        sub_q    [SLOT_COUNT];
  mfsm_pkg::sub_t        sub_d    [SLOT_COUNT];
  mfsm_pkg::sub_t        reuse_q  [SLOT_COUNT];
  mfsm_pkg::sub_t        reuse_d  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] opened_q, opened_d;
  mfsm_pkg::sub_t        cnt_q, cnt_d;
  logic                  wa_q, wa_d;
  logic [IdxW-1:0]       wi_q, wi_d;
  logic                  pv_q, pv_d;
  logic [IdxW-1:0]       pi_q, pi_d;
  logic                  pp_q, pp_d;

  // Result register
  logic                          res_valid_q;
  logic                          write_valid_q;
  logic [mfsm_pkg::SLOT_W-1:0]   write_slot_q;
  logic                          taken_q;
  logic                          ready_q;
  logic                          has_frame_q;
  logic [mfsm_pkg::SLOT_W-1:0]   latest_q;

  logic                  accept;
  logic [SLOT_COUNT-1:0] mask_ext;
  logic [SLOT_COUNT-1:0] eligible;
  logic [SLOT_COUNT-1:0] retire;
  logic [SLOT_COUNT-1:0] writing_vec;
  logic                  found;
  logic [IdxW-1:0]       newest;
  logic                  do_promote;
  logic                  claimed;
  logic                  taken;
  logic                  ready;
  logic                  idx_in_range;
  logic [IdxW-1:0]       idx;
  mfsm_pkg::sub_t        opened_sub;
  mfsm_pkg::sub_t        cnt_inc;

  // Every word is finished in a single pass, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= op_i;
      slot_index_q <= slot_index_i;
      mask_q       <= fence_done_mask_i;
      failed_q     <= signal_failed_i;
    end
  end

  // Fence bits beyond the mask width count as not complete.
  assign mask_ext = SLOT_COUNT'(mask_q);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      eligible[i]    = (st_q[i] == mfsm_pkg::ST_PENDING) && mask_ext[i];
      writing_vec[i] = (st_q[i] == mfsm_pkg::ST_WRITING);
    end
  end

  mfsm_newest_sel #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_newest_sel (
    .eligible_i(eligible),
    .sub_i     (sub_q),
    .found_o   (found),
    .newest_o  (newest)
  );

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      retire[i] = found && pv_q && (pi_q == IdxW'(i)) && (newest != IdxW'(i)) &&
                  (st_q[i] == mfsm_pkg::ST_PUBLISHED);
    end
  end

  assign do_promote = in_valid_q &&
                      (((op_q == mfsm_pkg::OP_ACQUIRE) && !wa_q) ||
                       (op_q == mfsm_pkg::OP_POLL));

  assign idx_in_range = (int'(slot_index_q) < SLOT_COUNT);
  assign idx          = IdxW'(slot_index_q);
  assign opened_sub   = sub_q[idx];
  assign cnt_inc      = cnt_q + mfsm_pkg::SUB_W'(1);

  always_comb begin
    st_d     = st_q;
    sub_d    = sub_q;
    reuse_d  = reuse_q;
    opened_d = opened_q;
    cnt_d    = cnt_q;
    wa_d     = wa_q;
    wi_d     = wi_q;
    pv_d     = pv_q;
    pi_d     = pi_q;
    pp_d     = pp_q;
    taken    = 1'b0;
    ready    = 1'b0;
    claimed  = 1'b0;

    // Promotion: publish the newest completed slot, retire the old one and free the other completed slots.
    if (do_promote && found) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (retire[i]) begin
          st_d[i]     = mfsm_pkg::ST_RETIRED;
          opened_d[i] = 1'b0;
          reuse_d[i]  = sub_q[i] + mfsm_pkg::SUB_W'(mfsm_pkg::REUSE_GAP);
        end else if (eligible[i]) begin
          st_d[i] = (newest == IdxW'(i)) ? mfsm_pkg::ST_PUBLISHED : mfsm_pkg::ST_FREE;
        end
      end
      pv_d = 1'b1;
      pi_d = newest;
      pp_d = 1'b1;
    end

    if (in_valid_q) begin
      case (op_q)
        mfsm_pkg::OP_ACQUIRE: begin
          if (!wa_q) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (st_d[i] == mfsm_pkg::ST_RETIRED && opened_d[i]) begin
                st_d[i]     = mfsm_pkg::ST_FREE;
                opened_d[i] = 1'b0;
              end
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!claimed && st_d[i] == mfsm_pkg::ST_FREE) begin
                st_d[i] = mfsm_pkg::ST_WRITING;
                wa_d    = 1'b1;
                wi_d    = IdxW'(i);
                claimed = 1'b1;
              end
            end
          end
        end
        mfsm_pkg::OP_COMMIT: begin
          if (wa_q) begin
            taken = 1'b1;
            if (failed_q) begin
              st_d[wi_q] = mfsm_pkg::ST_FREE;
            end else begin
              cnt_d       = cnt_inc;
              sub_d[wi_q] = cnt_inc;
              st_d[wi_q]  = mfsm_pkg::ST_PENDING;
            end
            wa_d = 1'b0;
            wi_d = '0;
          end
        end
        mfsm_pkg::OP_POLL: begin
          ready = pp_d;
          pp_d  = 1'b0;
        end
        mfsm_pkg::OP_OPENED: begin
          // A slot that was never submitted carries number zero and is ignored.
          if (idx_in_range && (opened_sub != '0)) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (st_q[i] == mfsm_pkg::ST_RETIRED && opened_sub >= reuse_q[i]) begin
                opened_d[i] = 1'b1;
              end
            end
          end
        end
        mfsm_pkg::OP_CLEAR: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            st_d[i]    = mfsm_pkg::ST_FREE;
            sub_d[i]   = '0;
            reuse_d[i] = '0;
          end
          opened_d = '0;
          cnt_d    = '0;
          wa_d     = 1'b0;
          wi_d     = '0;
          pv_d     = 1'b0;
          pi_d     = '0;
          pp_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st_q[i]    <= mfsm_pkg::ST_FREE;
        sub_q[i]   <= '0;
        reuse_q[i] <= '0;
      end
      opened_q <= '0;
      cnt_q    <= '0;
      wa_q     <= 1'b0;
      wi_q     <= '0;
      pv_q     <= 1'b0;
      pi_q     <= '0;
      pp_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      sub_q    <= sub_d;
      reuse_q  <= reuse_d;
      opened_q <= opened_d;
      cnt_q    <= cnt_d;
      wa_q     <= wa_d;
      wi_q     <= wi_d;
      pv_q     <= pv_d;
      pi_q     <= pi_d;
      pp_q     <= pp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      write_valid_q <= wa_d;
      write_slot_q  <= wa_d ? mfsm_pkg::SLOT_W'(wi_d) : '0;
      taken_q       <= taken;
      ready_q       <= ready;
      has_frame_q   <= pv_d;
      latest_q      <= pv_d ? mfsm_pkg::SLOT_W'(pi_d) : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign write_valid_o  = write_valid_q;
  assign write_slot_o   = write_slot_q;
  assign commit_taken_o = taken_q;
  assign fresh_frame_o  = ready_q;
  assign has_frame_o    = has_frame_q;
  assign latest_slot_o  = latest_q;

  a_writing_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wa_q |-> (st_q[wi_q] == mfsm_pkg::ST_WRITING))
    else $error("claimed write slot is not in the writing state");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(writing_vec) && (wa_q || (writing_vec == '0)))
    else $error("writing slots disagree with the write claim");

  a_published_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (st_q[pi_q] == mfsm_pkg::ST_PUBLISHED))
    else $error("published index does not point at a published slot");

  a_ready_only_on_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && ready_q) |-> ($past(op_q) == mfsm_pkg::OP_POLL))
    else $error("fresh frame reported for a word that was not a poll");

endmodule

`default_nettype wire
